@@ rtl/rde_pkg.sv @@
// ----------------------------------------------------------------------------
// rde_pkg
// Shared state type, constants and base-clamping helper for the radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

	localparam int VALUE_WIDTH_DEF = 31;
	localparam int RADIX_W         = 5;
	localparam int DIGIT_W         = 4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] BASE_MIN    = 5'd2;
	localparam logic [RADIX_W-1:0] BASE_MAX    = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} rde_state_t;

	// Register values below two act as base two, values above sixteen as base sixteen.
	function automatic logic [RADIX_W-1:0] eff_base(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] b;
		b = r;
		if (r < BASE_MIN) begin
			b = BASE_MIN;
		end else if (r > BASE_MAX) begin
			b = BASE_MAX;
		end
		return b;
	endfunction

endpackage

@@ rtl/radix_digit_emitter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts an unsigned integer to base-radix digits, most significant first.
// ----------------------------------------------------------------------------
// One item is converted at a time. The value is shifted in one bit per pass,
// most significant bit first, and each pass doubles a circulating register of
// VALUE_WIDTH base-radix digits through a single 4-bit digit ALU, one digit per
// cycle. Conversion therefore runs one pass per value bit, each pass walking
// the whole digit loop. Emission then walks the digit register from the top,
// one position at a time: leading zero positions are skipped without output,
// and each digit waits to be emitted while the output is stalled. A new item
// is taken while the final digit of the previous one still waits in the output
// register.
module radix_digit_emitter
	import rde_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RADIX_W-1:0]     cfg_wdata,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   digit_valid,
	input  logic                   digit_ready,
	output logic [DIGIT_W-1:0]     digit,
	output logic                   last
);

	localparam int NDIG = VALUE_WIDTH;
	localparam int PW   = $clog2(NDIG);
	localparam int BW   = $clog2(VALUE_WIDTH);

	localparam logic [PW-1:0] POS_TOP = PW'(NDIG - 1);
	localparam logic [BW-1:0] BIT_TOP = BW'(VALUE_WIDTH - 1);

	rde_state_t state_q, state_d;

	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [DIGIT_W-1:0]     dig_q [NDIG];
	logic [PW-1:0]          pos_q;
	logic [BW-1:0]          bcnt_q;
	logic                   carry_q;
	logic                   started_q;
	logic                   out_valid_q;
	logic [DIGIT_W-1:0]     out_digit_q;
	logic                   out_last_q;

	logic                   accept;
	logic                   conv_step;
	logic                   emit_shift;
	logic                   emit_load;
	logic                   out_free;
	logic                   want_emit;

	logic [RADIX_W-1:0]     base;
	logic                   carry_in;
	logic [RADIX_W-1:0]     dbl;
	logic                   ge;
	logic [DIGIT_W-1:0]     new_dig;

	// Digit ALU: doubles the head digit and adds the incoming carry, modulo the base.
	always_comb begin
		base     = eff_base(radix_q);
		carry_in = (pos_q == '0) ? val_q[VALUE_WIDTH-1] : carry_q;
		dbl      = {1'b0, dig_q[0]} + {1'b0, dig_q[0]} + RADIX_W'(carry_in);
		ge       = (dbl >= base);
		new_dig  = ge ? DIGIT_W'(dbl - base) : DIGIT_W'(dbl);
	end

	assign out_free  = !out_valid_q || digit_ready;
	assign want_emit = started_q || (dig_q[NDIG-1] != '0) || (pos_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		accept     = 1'b0;
		conv_step  = 1'b0;
		emit_shift = 1'b0;
		emit_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					accept  = 1'b1;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				conv_step = 1'b1;
				if (pos_q == POS_TOP && bcnt_q == '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!want_emit) begin
					emit_shift = 1'b1;
				end else if (out_free) begin
					emit_shift = 1'b1;
					emit_load  = 1'b1;
					if (pos_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_RESET;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			bcnt_q      <= '0;
			carry_q     <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (digit_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				pos_q   <= '0;
				bcnt_q  <= BIT_TOP;
				carry_q <= 1'b0;
			end else if (conv_step) begin
				carry_q <= ge;
				if (pos_q == POS_TOP) begin
					pos_q     <= POS_TOP;
					bcnt_q    <= bcnt_q - 1'b1;
					started_q <= 1'b0;
					if (bcnt_q != '0) begin
						pos_q <= '0;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (emit_shift) begin
				pos_q <= pos_q - 1'b1;
				if (emit_load) begin
					started_q <= 1'b1;
				end
			end
		end
	end

	// The digit register rotates toward index zero while converting, so each
	// pass returns the least significant digit to the head. Emission shifts
	// the other way and reads the most significant position.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= '0;
			end
		end else if (conv_step) begin
			for (int i = 0; i < NDIG - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
			dig_q[NDIG-1] <= new_dig;
			if (pos_q == POS_TOP) begin
				val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end else if (emit_shift) begin
			for (int i = 1; i < NDIG; i++) begin
				dig_q[i] <= dig_q[i-1];
			end
			dig_q[0] <= '0;
		end
		if (emit_load) begin
			out_digit_q <= dig_q[NDIG-1];
			out_last_q  <= (pos_q == '0);
		end
	end

	assign digit_valid = out_valid_q;
	assign digit       = out_digit_q;
	assign last        = out_last_q;

endmodule

@@ rtl/rde_checker.sv @@
// ----------------------------------------------------------------------------
// rde_checker
// Port-level checks for the radix digit emitter, bound to the top level.
// ----------------------------------------------------------------------------
module rde_checker
	import rde_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic               digit_valid,
	input logic               digit_ready,
	input logic [DIGIT_W-1:0] digit,
	input logic               last
);

	// Accepting an item moves the block into conversion, so it is busy right after an item.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item_ready stayed high right after an item was accepted");

	// A digit other than the final one means the current item is still being emitted.
	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !last |-> !item_ready)
		else $error("input taken while an item still has digits to emit");

	// A stalled digit keeps its value and its last flag.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_ready |=> digit_valid && $stable(digit) && $stable(last))
		else $error("stalled digit changed or was dropped");

endmodule

bind radix_digit_emitter rde_checker u_rde_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.digit_valid(digit_valid),
	.digit_ready(digit_ready),
	.digit      (digit),
	.last       (last)
);

@@ verif/radix_digit_emitter_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_test
// Self-checking bench for the radix digit emitter. Integers are sent through a
// valid/ready channel under a series of radix settings. A local digit
// expansion predicts each digit and its last flag, and every digit that comes
// out is checked against it in order.
// ----------------------------------------------------------------------------
module radix_digit_emitter_test;
	import rde_pkg::*;

	localparam int IDLE_PCT    = 8;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 2500;
	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN       = 1100;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} digit_rec_t;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_we      = 1'b0;
	logic [RADIX_W-1:0]         cfg_wdata   = RADIX_RESET;
	logic                       item_valid  = 1'b0;
	logic                       item_ready;
	logic [VALUE_WIDTH_DEF-1:0] value       = '0;
	logic                       digit_valid;
	logic                       digit_ready = 1'b0;
	logic [DIGIT_W-1:0]         digit;
	logic                       last;

	logic [VALUE_WIDTH_DEF-1:0] pending[$];
	digit_rec_t                 digits_due[$];
	logic [RADIX_W-1:0]         radix_shadow = RADIX_RESET;
	logic                       item_took    = 1'b0;
	bit                         no_idle      = 1'b0;
	int                         digits_taken = 0;
	int                         hold_left    = 0;
	bit                         hold_done    = 1'b0;
	int                         quiet        = 0;
	int                         mismatches   = 0;

	radix_digit_emitter #(
		.VALUE_WIDTH(VALUE_WIDTH_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value(value),
		.digit_valid(digit_valid),
		.digit_ready(digit_ready),
		.digit(digit),
		.last(last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("%0t: mismatch on %s after %0d digits: got %0d, want %0d",
			$time, what, digits_taken, got, want);
	endtask

	// Expected digits of one value, most significant first, appended to digits_due.
	function automatic void expand_digits(input logic [VALUE_WIDTH_DEF-1:0] v,
			input logic [RADIX_W-1:0] r);
		longint unsigned rest, base, pw, d;
		digit_rec_t rec;
		base = 64'(r);
		if (base < BASE_MIN) begin
			base = BASE_MIN;
		end else if (base > BASE_MAX) begin
			base = BASE_MAX;
		end
		rest = 64'(v);
		pw = 1;
		while (pw <= rest / base) pw = pw * base;
		forever begin
			d = rest / pw;
			rest = rest - d * pw;
			rec.digit = d[DIGIT_W-1:0];
			rec.last = (pw == 1);
			digits_due.push_back(rec);
			if (pw == 1) break;
			pw = pw / base;
		end
	endfunction

	// Sender: a new item is offered only once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!item_valid || item_took)) begin
			if (pending.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				item_valid <= 1'b1;
				value <= pending.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that lets the block back up.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			digit_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && digits_taken >= HOLD_AT) begin
			digit_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			digit_ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin : watch_digits
		digit_rec_t want;
		if (arst_n) begin
			item_took <= item_valid && item_ready;
			if (cfg_we) radix_shadow <= cfg_wdata;
			if (item_valid && item_ready) expand_digits(value, radix_shadow);
			if (digit_valid && digit_ready) begin
				digits_taken <= digits_taken + 1;
				if (digits_due.size() == 0) begin
					report_mismatch("unexpected digit", int'(digit), 0);
				end else begin
					want = digits_due.pop_front();
					if (digit !== want.digit)
						report_mismatch("digit", int'(digit), int'(want.digit));
					if (last !== want.last)
						report_mismatch("last", int'(last), int'(want.last));
				end
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (digit_valid && digit_ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("Verification failed");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic settle();
		while (pending.size() != 0 || item_valid || digits_due.size() != 0) @(negedge clk);
	endtask

	// The register is only written once the block has drained.
	task automatic set_radix(input logic [RADIX_W-1:0] r, input bit calm);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= r;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		no_idle = calm;
	endtask

	task automatic push_random(input logic [RADIX_W-1:0] r, input int n);
		longint unsigned rb, pw;
		int k;
		rb = 64'((r < BASE_MIN) ? BASE_MIN : (r > BASE_MAX) ? BASE_MAX : r);
		repeat (n) begin
			case ($urandom_range(0, 3))
				0, 1: pending.push_back(VALUE_WIDTH_DEF'($urandom()));
				2: pending.push_back(VALUE_WIDTH_DEF'($urandom_range(0, 40)));
				default: begin
					// Near a power of the base, where the digit count changes.
					pw = 1;
					k = int'($urandom_range(0, 30));
					repeat (k) if (pw * rb < 64'h8000_0000) pw = pw * rb;
					pending.push_back(VALUE_WIDTH_DEF'(pw + $urandom_range(0, 2) - 1));
				end
			endcase
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_radix(5'd10, 1'b0);
		pending.push_back(31'd0);
		pending.push_back(31'd1);
		pending.push_back(31'd9);
		pending.push_back(31'd10);
		pending.push_back(31'd11);
		pending.push_back(31'd100);
		pending.push_back(31'd1000000000);
		pending.push_back(31'd1000000007);
		pending.push_back(31'd999999999);
		pending.push_back(31'h7FFF_FFFF);

		set_radix(5'd2, 1'b0);
		pending.push_back(31'd0);
		pending.push_back(31'd1);
		pending.push_back(31'd2);
		pending.push_back(31'd3);
		pending.push_back(31'h4000_0000);
		pending.push_back(31'h3FFF_FFFF);

		set_radix(5'd16, 1'b0);
		pending.push_back(31'd15);
		pending.push_back(31'd16);
		pending.push_back(31'h1000_0000);
		pending.push_back(31'h0F0F_0F0F);
		pending.push_back(31'h7FFF_FFFF);

		// Register values outside 2 to 16 are clamped by the block.
		set_radix(5'd0, 1'b0);
		pending.push_back(31'd5);
		pending.push_back(31'h2AAA_AAAA);
		set_radix(5'd1, 1'b0);
		pending.push_back(31'd6);
		set_radix(5'd17, 1'b0);
		pending.push_back(31'd255);
		set_radix(5'd31, 1'b0);
		pending.push_back(31'd16);

		set_radix(5'd3, 1'b0);
		push_random(5'd3, 25);
		set_radix(5'd10, 1'b0);
		push_random(5'd10, 25);
		set_radix(5'd16, 1'b1);
		push_random(5'd16, 25);
		set_radix(5'd7, 1'b0);
		push_random(5'd7, 25);
		set_radix(5'd31, 1'b0);
		push_random(5'd31, 25);
		set_radix(5'd2, 1'b0);
		push_random(5'd2, 20);
		set_radix(5'd0, 1'b0);
		push_random(5'd0, 15);
		set_radix(5'd13, 1'b0);
		push_random(5'd13, 25);
		begin : any_radix
			logic [RADIX_W-1:0] r;
			r = RADIX_W'($urandom_range(0, 31));
			set_radix(r, 1'b0);
			push_random(r, 10);
		end

		settle();
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/rde_pkg.sv
rtl/radix_digit_emitter.sv
rtl/rde_checker.sv
verif/radix_digit_emitter_test.sv
